// File: rtl/tlbms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbms_pkg: shared types and constants of the multi-size TLB
// Request and level codes, table ids, sequencer states and the command and
// response bundles of the shared hash unit.
// ----------------------------------------------------------------------------
package tlbms_pkg;

    localparam int L1_GIGA_ENTRIES  = 4;
    localparam int L1_HUGE_ENTRIES  = 32;
    localparam int L1_BASE_ENTRIES  = 64;
    localparam int L2_GIGA_ENTRIES  = 16;
    localparam int L2_MIXED_ENTRIES = 1536;
    localparam int VADDR_BITS       = 48;

    localparam int ADDR_W  = 48;
    localparam int REQ_W   = 2;
    localparam int LEVEL_W = 3;
    localparam int SLOT_W  = 14;
    localparam int HASH_W  = 32;
    localparam int RECIP_W = 33;

    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 2'd2;

    localparam logic [LEVEL_W-1:0] LVL_NONE = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_GIGA = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_HUGE = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_BASE = 3'd4;

    localparam int OFF_BASE = 12;
    localparam int OFF_HUGE = 21;
    localparam int OFF_GIGA = 30;

    localparam int TBL_L1G = 0;
    localparam int TBL_L1H = 1;
    localparam int TBL_L1B = 2;
    localparam int TBL_L2G = 3;
    localparam int TBL_L2M = 4;
    localparam int NUM_TBL = 5;
    localparam int TBL_W   = 3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_L_HASH,
        S_L_WAIT,
        S_L_READ,
        S_L_CHECK,
        S_RESP,
        S_I_HASH,
        S_I_WAIT,
        S_I_READ,
        S_I_CHECK,
        S_V_HASH,
        S_V_WAIT,
        S_V_WRITE
    } t_state;

    // recip is floor(2^32 / modulus) of the target table
    typedef struct packed {
        logic               start;
        logic [ADDR_W-1:0]  key;
        logic [SLOT_W-1:0]  modulus;
        logic [RECIP_W-1:0] recip;
    } t_hash_cmd;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] slot;
    } t_hash_rsp;

    // page offset width of a level
    function automatic logic [5:0] offset_bits(input logic [LEVEL_W-1:0] lvl);
        logic [5:0] b;
        case (lvl)
            LVL_GIGA: b = 6'(OFF_GIGA);
            LVL_HUGE: b = 6'(OFF_HUGE);
            default:  b = 6'(OFF_BASE);
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tlbms_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbms_req_if: request channel
// Valid/ready channel carrying one lookup, insert or flush request a beat.
// ----------------------------------------------------------------------------
interface tlbms_req_if;
    logic                                valid;
    logic                                ready;
    logic [tlbms_pkg::REQ_W-1:0]         req_type;
    logic [tlbms_pkg::ADDR_W-1:0]        vaddr;
    logic [tlbms_pkg::ADDR_W-1:0]        paddr;
    logic [tlbms_pkg::LEVEL_W-1:0]       page_level;

    modport source (output valid, req_type, vaddr, paddr, page_level, input ready);
    modport sink   (input valid, req_type, vaddr, paddr, page_level, output ready);
endinterface
`default_nettype wire

// File: rtl/tlbms_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbms_rsp_if: lookup response channel
// Valid/ready channel carrying one translation result a beat.
// ----------------------------------------------------------------------------
interface tlbms_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic [tlbms_pkg::LEVEL_W-1:0]       hit_level;
    logic [tlbms_pkg::ADDR_W-1:0]        phys_addr;

    modport source (output valid, hit, hit_level, phys_addr, input ready);
    modport sink   (input valid, hit, hit_level, phys_addr, output ready);
endinterface
`default_nettype wire

// File: rtl/tlbms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbms_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/tlbms_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbms_hash: shared one-at-a-time hash and slot reduction unit
// One key byte per cycle, then a final mix and a reduction by reciprocal
// multiplication against the table size: multiply, subtract, fold. Done pulses one cycle
// with the slot.
// ----------------------------------------------------------------------------
module tlbms_hash (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tlbms_pkg::t_hash_cmd  i_cmd,
    output tlbms_pkg::t_hash_rsp       o_rsp
);
    localparam int HW        = tlbms_pkg::HASH_W;
    localparam int SW        = tlbms_pkg::SLOT_W;
    localparam int RW        = tlbms_pkg::RECIP_W;
    localparam int ROUNDS    = 8;
    localparam int MIX_STEP  = ROUNDS;
    localparam int MUL_STEP  = MIX_STEP + 1;
    localparam int SUB_STEP  = MIX_STEP + 2;
    localparam int LAST_STEP = MIX_STEP + 3;
    localparam int CNT_W     = $clog2(LAST_STEP + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [tlbms_pkg::ADDR_W-1:0]  r_key;
    logic [HW-1:0]                 r_h;
    logic [HW-1:0]                 r_q;
    logic [SW:0]                   r_r;
    logic [SW-1:0]                 r_rem;
    logic [SW-1:0]                 r_mod;
    logic [RW-1:0]                 r_recip;

    logic [HW-1:0]   w_h1, w_h2, w_h3, w_f1, w_f2, w_f3;
    logic [2*HW-1:0] w_prod;
    logic [HW-1:0]   w_qn, w_diff;
    logic [SW:0]     w_rem_s;
    logic [SW-1:0]   w_rem_n;

    always_comb begin
        w_h1    = r_h + HW'(r_key[7:0]);
        w_h2    = w_h1 + (w_h1 << 10);
        w_h3    = w_h2 ^ (w_h2 >> 6);
        w_f1    = r_h + (r_h << 3);
        w_f2    = w_f1 ^ (w_f1 >> 11);
        w_f3    = w_f2 + (w_f2 << 15);
        // quotient estimate is exact or one low, so the remainder is below 2 * modulus
        w_prod  = (2*HW)'(r_h) * (2*HW)'(r_recip);
        w_qn    = r_q * HW'(r_mod);
        w_diff  = r_h - w_qn;
        w_rem_s = r_r - {1'b0, r_mod};
        w_rem_n = (r_r >= {1'b0, r_mod}) ? w_rem_s[SW-1:0] : r_r[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LAST_STEP)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key   <= i_cmd.key;
            r_h     <= '0;
            r_rem   <= '0;
            r_mod   <= i_cmd.modulus;
            r_recip <= i_cmd.recip;
        end else if (r_busy) begin
            if (r_cnt < CNT_W'(MIX_STEP)) begin
                r_h   <= w_h3;
                r_key <= r_key >> 8;
            end else if (r_cnt == CNT_W'(MIX_STEP)) begin
                r_h <= w_f3;
            end else if (r_cnt == CNT_W'(MUL_STEP)) begin
                r_q <= w_prod[2*HW-1:HW];
            end else if (r_cnt == CNT_W'(SUB_STEP)) begin
                r_r <= w_diff[SW:0];
            end else begin
                // fold the remainder back below the modulus
                r_rem <= w_rem_n;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.slot = r_rem;
endmodule
`default_nettype wire

// File: rtl/two_level_multi_size_tlb.sv
`timescale 1ns / 1ps
`default_nettype none
// Each table probe runs: hash start, the shared hash unit (byte rounds, mix,
//   reduction, done), a RAM read, then a compare. A lookup takes one to six probes;
//   an insert hashes, reads and writes its L1 table, then hashes and writes the victim
//   into L2 when one moves. One request at a time; ready only when idle. Reset and
//   flush run a clearing pass over max(table entries) addresses, 1536 with the default
//   sizes, before the first request is taken.
// ----------------------------------------------------------------------------
// two_level_multi_size_tlb: two-level TLB for 1 GB, 2 MB and 4 KB pages
// Five direct-mapped tables in RAM, indexed through one shared hash unit under
// a small sequencer. Lookups answer on the response channel.
// ----------------------------------------------------------------------------
module two_level_multi_size_tlb #(
    parameter int L1_GIGA_ENTRIES  = tlbms_pkg::L1_GIGA_ENTRIES,
    parameter int L1_HUGE_ENTRIES  = tlbms_pkg::L1_HUGE_ENTRIES,
    parameter int L1_BASE_ENTRIES  = tlbms_pkg::L1_BASE_ENTRIES,
    parameter int L2_GIGA_ENTRIES  = tlbms_pkg::L2_GIGA_ENTRIES,
    parameter int L2_MIXED_ENTRIES = tlbms_pkg::L2_MIXED_ENTRIES,
    parameter int VADDR_BITS       = tlbms_pkg::VADDR_BITS
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tlbms_req_if.sink    i_req,
    tlbms_rsp_if.source  o_rsp
);
    localparam int AW      = tlbms_pkg::ADDR_W;
    localparam int LW      = tlbms_pkg::LEVEL_W;
    localparam int SW      = tlbms_pkg::SLOT_W;
    localparam int RW      = tlbms_pkg::RECIP_W;
    localparam int OFF_B   = tlbms_pkg::OFF_BASE;
    // virtual bits that can reach a key: the request carries 48 address bits
    localparam int VA_EFF  = (VADDR_BITS < AW) ? VADDR_BITS : AW;
    localparam int KEY_W   = VA_EFF - OFF_B;
    localparam int ENTRY_W = 2 + 2 * KEY_W;
    localparam int NT      = tlbms_pkg::NUM_TBL;
    localparam int MAX_A   = (L1_GIGA_ENTRIES > L1_HUGE_ENTRIES) ? L1_GIGA_ENTRIES
                                                                 : L1_HUGE_ENTRIES;
    localparam int MAX_B   = (L1_BASE_ENTRIES > L2_GIGA_ENTRIES) ? L1_BASE_ENTRIES
                                                                 : L2_GIGA_ENTRIES;
    localparam int MAX_C   = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int CLR_DEPTH = (MAX_C > L2_MIXED_ENTRIES) ? MAX_C : L2_MIXED_ENTRIES;
    localparam int CLR_W   = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;
    localparam int PRB_W   = 3;
    localparam logic [PRB_W-1:0] LAST_PROBE = 3'd5;

    // floor(2^32 / table size), fixed at elaboration
    localparam logic [RW-1:0] RCP_L1G = RW'((64'd1 << 32) / 64'(L1_GIGA_ENTRIES));
    localparam logic [RW-1:0] RCP_L1H = RW'((64'd1 << 32) / 64'(L1_HUGE_ENTRIES));
    localparam logic [RW-1:0] RCP_L1B = RW'((64'd1 << 32) / 64'(L1_BASE_ENTRIES));
    localparam logic [RW-1:0] RCP_L2G = RW'((64'd1 << 32) / 64'(L2_GIGA_ENTRIES));
    localparam logic [RW-1:0] RCP_L2M = RW'((64'd1 << 32) / 64'(L2_MIXED_ENTRIES));

    localparam logic [1:0] WANT_ANY  = 2'd0;
    localparam logic [1:0] WANT_HUGE = 2'd1;
    localparam logic [1:0] WANT_BASE = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             huge;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] frame;
    } t_entry;

    function automatic int tbl_depth(input int t);
        int d;
        case (t)
            tlbms_pkg::TBL_L1G: d = L1_GIGA_ENTRIES;
            tlbms_pkg::TBL_L1H: d = L1_HUGE_ENTRIES;
            tlbms_pkg::TBL_L1B: d = L1_BASE_ENTRIES;
            tlbms_pkg::TBL_L2G: d = L2_GIGA_ENTRIES;
            default:            d = L2_MIXED_ENTRIES;
        endcase
        return d;
    endfunction

    function automatic logic [RW-1:0] tbl_recip(input int t);
        logic [RW-1:0] r;
        case (t)
            tlbms_pkg::TBL_L1G: r = RCP_L1G;
            tlbms_pkg::TBL_L1H: r = RCP_L1H;
            tlbms_pkg::TBL_L1B: r = RCP_L1B;
            tlbms_pkg::TBL_L2G: r = RCP_L2G;
            default:            r = RCP_L2M;
        endcase
        return r;
    endfunction

    // drop the page offset bits of a level from a frame field
    function automatic logic [KEY_W-1:0] key_of(input logic [KEY_W-1:0] f,
                                                 input logic [LW-1:0] lvl);
        logic [KEY_W-1:0] m;
        m = '1;
        case (lvl)
            tlbms_pkg::LVL_GIGA: m = m << (tlbms_pkg::OFF_GIGA - OFF_B);
            tlbms_pkg::LVL_HUGE: m = m << (tlbms_pkg::OFF_HUGE - OFF_B);
            default:             m = '1;
        endcase
        return f & m;
    endfunction

    // sequencer and captured request
    tlbms_pkg::t_state   r_state, n_state;
    logic [CLR_W-1:0]    r_clr_cnt, n_clr_cnt;
    logic [AW-1:0]       r_vaddr, n_vaddr;
    logic [AW-1:0]       r_paddr, n_paddr;
    logic [LW-1:0]       r_level, n_level;
    logic [PRB_W-1:0]    r_probe, n_probe;
    logic [SW-1:0]       r_slot, n_slot;
    t_entry              r_victim, n_victim;
    // lookup result waiting for the output register
    logic                r_res_hit, n_res_hit;
    logic [LW-1:0]       r_res_level, n_res_level;
    logic [KEY_W-1:0]    r_res_frame, n_res_frame;
    // output register
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [LW-1:0]       r_out_level, n_out_level;
    logic [AW-1:0]       r_out_phys, n_out_phys;

    tlbms_pkg::t_hash_cmd w_hash_cmd;
    tlbms_pkg::t_hash_rsp w_hash_rsp;

    logic [ENTRY_W-1:0]  w_rdata [NT];
    logic [NT-1:0]       w_we;
    t_entry              w_wdata;
    logic                w_accept;
    logic [KEY_W-1:0]    w_va_field, w_pa_field;
    logic [tlbms_pkg::TBL_W-1:0] w_p_tbl, w_l1_tbl, w_l2_tbl, w_cur_tbl;
    logic [LW-1:0]       w_p_lvl;
    logic [1:0]          w_p_want;
    logic [KEY_W-1:0]    w_p_key, w_i_key, w_hkey;
    t_entry              w_entry, w_new;
    logic                w_p_hit, w_move;
    logic [AW-1:0]       w_off_mask;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_va_field = r_vaddr[VA_EFF-1:OFF_B];
    assign w_pa_field = r_paddr[VA_EFF-1:OFF_B];

    // probe order: L1 giga, L1 huge, L1 base, L2 giga, L2 mixed as 2 MB, as 4 KB
    always_comb begin
        case (r_probe)
            3'd0: begin
                w_p_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L1G);
                w_p_lvl = tlbms_pkg::LVL_GIGA; w_p_want = WANT_ANY;
            end
            3'd1: begin
                w_p_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L1H);
                w_p_lvl = tlbms_pkg::LVL_HUGE; w_p_want = WANT_ANY;
            end
            3'd2: begin
                w_p_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L1B);
                w_p_lvl = tlbms_pkg::LVL_BASE; w_p_want = WANT_ANY;
            end
            3'd3: begin
                w_p_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L2G);
                w_p_lvl = tlbms_pkg::LVL_GIGA; w_p_want = WANT_ANY;
            end
            3'd4: begin
                w_p_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L2M);
                w_p_lvl = tlbms_pkg::LVL_HUGE; w_p_want = WANT_HUGE;
            end
            default: begin
                w_p_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L2M);
                w_p_lvl = tlbms_pkg::LVL_BASE; w_p_want = WANT_BASE;
            end
        endcase
    end

    // insert targets by page size
    always_comb begin
        case (r_level)
            tlbms_pkg::LVL_GIGA: begin
                w_l1_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L1G);
                w_l2_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L2G);
            end
            tlbms_pkg::LVL_HUGE: begin
                w_l1_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L1H);
                w_l2_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L2M);
            end
            default: begin
                w_l1_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L1B);
                w_l2_tbl = tlbms_pkg::TBL_W'(tlbms_pkg::TBL_L2M);
            end
        endcase
    end

    always_comb begin
        w_p_key = key_of(w_va_field, w_p_lvl);
        w_i_key = key_of(w_va_field, r_level);
        case (r_state)
            tlbms_pkg::S_I_HASH, tlbms_pkg::S_I_WAIT, tlbms_pkg::S_I_READ,
            tlbms_pkg::S_I_CHECK: begin
                w_cur_tbl = w_l1_tbl;
                w_hkey    = w_i_key;
            end
            tlbms_pkg::S_V_HASH, tlbms_pkg::S_V_WAIT, tlbms_pkg::S_V_WRITE: begin
                w_cur_tbl = w_l2_tbl;
                w_hkey    = r_victim.key;
            end
            default: begin
                w_cur_tbl = w_p_tbl;
                w_hkey    = w_p_key;
            end
        endcase
    end

    // one hash request a probe or insert step
    always_comb begin
        w_hash_cmd.start   = (r_state == tlbms_pkg::S_L_HASH) ||
                             (r_state == tlbms_pkg::S_I_HASH) ||
                             (r_state == tlbms_pkg::S_V_HASH);
        w_hash_cmd.key     = AW'(w_hkey) << OFF_B;
        w_hash_cmd.modulus = SW'(tbl_depth(int'(w_cur_tbl)));
        w_hash_cmd.recip   = tbl_recip(int'(w_cur_tbl));
    end

    tlbms_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_hash_cmd),
        .o_rsp   (w_hash_rsp)
    );

    // entry compare
    always_comb begin
        w_entry = t_entry'(w_rdata[w_cur_tbl]);
        w_p_hit = w_entry.valid && (w_entry.key == w_p_key) &&
                  !((w_p_want == WANT_HUGE) && !w_entry.huge) &&
                  !((w_p_want == WANT_BASE) && w_entry.huge);
        w_new.valid = 1'b1;
        w_new.huge  = (r_level == tlbms_pkg::LVL_HUGE);
        w_new.key   = w_i_key;
        w_new.frame = key_of(w_pa_field, r_level);
        w_move      = w_entry.valid && (w_entry.key != w_i_key);
        w_off_mask  = (AW'(1) << tlbms_pkg::offset_bits(r_res_level)) - AW'(1);
    end

    // RAM write control: L1 fill, L2 victim move; the clear pass is muxed in per table below
    always_comb begin
        w_we    = '0;
        w_wdata = '0;
        case (r_state)
            tlbms_pkg::S_I_CHECK: begin
                w_we[w_l1_tbl] = 1'b1;
                w_wdata        = w_new;
            end
            tlbms_pkg::S_V_WRITE: begin
                w_we[w_l2_tbl] = 1'b1;
                w_wdata        = r_victim;
            end
            default: begin
                w_we    = '0;
                w_wdata = '0;
            end
        endcase
    end

    for (genvar t = 0; t < NT; t++) begin : g_tbl
        localparam int D  = tbl_depth(t);
        localparam int TA = (D > 1) ? $clog2(D) : 1;
        logic          w_t_we;
        logic [TA-1:0] w_t_waddr;

        always_comb begin
            if (r_state == tlbms_pkg::S_CLEAR) begin
                w_t_we    = (int'(r_clr_cnt) < D);
                w_t_waddr = r_clr_cnt[TA-1:0];
            end else begin
                w_t_we    = w_we[t];
                w_t_waddr = r_slot[TA-1:0];
            end
        end

        tlbms_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (D)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_t_we),
            .i_waddr (w_t_waddr),
            .i_wdata (w_wdata),
            .i_raddr (r_slot[TA-1:0]),
            .o_rdata (w_rdata[t])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbms_pkg::S_CLEAR: begin
                if (r_clr_cnt == CLR_W'(CLR_DEPTH - 1)) n_state = tlbms_pkg::S_IDLE;
            end
            tlbms_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.req_type)
                        tlbms_pkg::REQ_LOOKUP: n_state = tlbms_pkg::S_L_HASH;
                        tlbms_pkg::REQ_INSERT: begin
                            if (i_req.page_level inside {[tlbms_pkg::LVL_GIGA :
                                                           tlbms_pkg::LVL_BASE]}) begin
                                n_state = tlbms_pkg::S_I_HASH;
                            end
                        end
                        tlbms_pkg::REQ_FLUSH: n_state = tlbms_pkg::S_CLEAR;
                        default: n_state = tlbms_pkg::S_IDLE;
                    endcase
                end
            end
            tlbms_pkg::S_L_HASH: n_state = tlbms_pkg::S_L_WAIT;
            tlbms_pkg::S_L_WAIT: begin
                if (w_hash_rsp.done) n_state = tlbms_pkg::S_L_READ;
            end
            tlbms_pkg::S_L_READ: n_state = tlbms_pkg::S_L_CHECK;
            tlbms_pkg::S_L_CHECK: begin
                if (w_p_hit || (r_probe == LAST_PROBE)) n_state = tlbms_pkg::S_RESP;
                else n_state = tlbms_pkg::S_L_HASH;
            end
            tlbms_pkg::S_RESP: begin
                if (!r_out_valid || o_rsp.ready) n_state = tlbms_pkg::S_IDLE;
            end
            tlbms_pkg::S_I_HASH: n_state = tlbms_pkg::S_I_WAIT;
            tlbms_pkg::S_I_WAIT: begin
                if (w_hash_rsp.done) n_state = tlbms_pkg::S_I_READ;
            end
            tlbms_pkg::S_I_READ: n_state = tlbms_pkg::S_I_CHECK;
            tlbms_pkg::S_I_CHECK: begin
                n_state = w_move ? tlbms_pkg::S_V_HASH : tlbms_pkg::S_IDLE;
            end
            tlbms_pkg::S_V_HASH: n_state = tlbms_pkg::S_V_WAIT;
            tlbms_pkg::S_V_WAIT: begin
                if (w_hash_rsp.done) n_state = tlbms_pkg::S_V_WRITE;
            end
            tlbms_pkg::S_V_WRITE: n_state = tlbms_pkg::S_IDLE;
            default: n_state = tlbms_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_clr_cnt   = r_clr_cnt;
        n_vaddr     = r_vaddr;
        n_paddr     = r_paddr;
        n_level     = r_level;
        n_probe     = r_probe;
        n_slot      = r_slot;
        n_victim    = r_victim;
        n_res_hit   = r_res_hit;
        n_res_level = r_res_level;
        n_res_frame = r_res_frame;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_hit   = r_out_hit;
        n_out_level = r_out_level;
        n_out_phys  = r_out_phys;

        // capture the request beat
        if (w_accept) begin
            n_vaddr   = i_req.vaddr;
            n_paddr   = i_req.paddr;
            n_level   = i_req.page_level;
            n_probe   = '0;
            n_clr_cnt = '0;
        end

        case (r_state)
            tlbms_pkg::S_CLEAR: n_clr_cnt = r_clr_cnt + 1'b1;
            tlbms_pkg::S_L_WAIT, tlbms_pkg::S_I_WAIT, tlbms_pkg::S_V_WAIT: begin
                if (w_hash_rsp.done) n_slot = w_hash_rsp.slot;
            end
            tlbms_pkg::S_L_CHECK: begin
                n_probe     = r_probe + 1'b1;
                n_res_hit   = w_p_hit;
                n_res_level = w_p_hit ? w_p_lvl : tlbms_pkg::LVL_NONE;
                n_res_frame = w_entry.frame;
            end
            tlbms_pkg::S_I_CHECK: n_victim = w_entry;
            tlbms_pkg::S_RESP: begin
                // load the output register once it is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_level = r_res_level;
                    n_out_phys  = r_res_hit ? ((AW'(r_res_frame) << OFF_B) |
                                               (r_vaddr & w_off_mask))
                                            : '0;
                end
            end
            default: n_slot = r_slot;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tlbms_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vaddr     <= n_vaddr;
        r_paddr     <= n_paddr;
        r_level     <= n_level;
        r_probe     <= n_probe;
        r_slot      <= n_slot;
        r_victim    <= n_victim;
        r_res_hit   <= n_res_hit;
        r_res_level <= n_res_level;
        r_res_frame <= n_res_frame;
        r_out_hit   <= n_out_hit;
        r_out_level <= n_out_level;
        r_out_phys  <= n_out_phys;
    end

    assign i_req.ready     = (r_state == tlbms_pkg::S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.hit       = r_out_hit;
    assign o_rsp.hit_level = r_out_level;
    assign o_rsp.phys_addr = r_out_phys;
endmodule
`default_nettype wire

// File: rtl/tlbms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlbms_checker: port-level checks of the TLB
// Watches the request and response channels and flags broken beats.
// ----------------------------------------------------------------------------
module tlbms_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_req_valid,
    input wire logic                               i_req_ready,
    input wire logic [tlbms_pkg::REQ_W-1:0]        i_req_type,
    input wire logic                               i_rsp_valid,
    input wire logic                               i_rsp_ready,
    input wire logic                               i_rsp_hit,
    input wire logic [tlbms_pkg::LEVEL_W-1:0]      i_rsp_level,
    input wire logic [tlbms_pkg::ADDR_W-1:0]       i_rsp_phys
);
    // drop any pending response on reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // hold a stalled response beat
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_hit) &&
        $stable(i_rsp_level) && $stable(i_rsp_phys))
        else $error("stalled response changed");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_hit |-> i_rsp_level == tlbms_pkg::LVL_NONE &&
        i_rsp_phys == '0)
        else $error("miss with nonzero level or address");

    a_hit_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_hit |-> i_rsp_level == tlbms_pkg::LVL_GIGA ||
        i_rsp_level == tlbms_pkg::LVL_HUGE || i_rsp_level == tlbms_pkg::LVL_BASE)
        else $error("hit with bad page level");

    // a lookup keeps the sequencer busy, so ready falls after an accepted lookup beat
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_type == tlbms_pkg::REQ_LOOKUP
        |=> !i_req_ready)
        else $error("ready right after a lookup beat");
endmodule

bind two_level_multi_size_tlb tlbms_checker u_tlbms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_hit   (o_rsp.hit),
    .i_rsp_level (o_rsp.hit_level),
    .i_rsp_phys  (o_rsp.phys_addr)
);
`default_nettype wire

// File: sim/two_level_multi_size_tlb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_multi_size_tlb_tb: self-checking bench of the multi-size TLB
// Drives lookups, inserts and flushes, then a random mix built around a small
// set of recently mapped addresses so that lookups hit every table. Every
// response beat is checked against a behavioral copy of all five tables or, for directed rows, a typed-in answer.
// ----------------------------------------------------------------------------
module two_level_multi_size_tlb_tb;
    import tlbms_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int  NUM_ITEMS  = 1350;
    localparam int  QUIET_TAIL = 150;
    localparam int  HOLD_AT    = 400;      // request count that starts the long hold-off
    localparam int  HOLD_LEN   = 3000;
    localparam int  CYCLE_MAX  = 4000000;
    localparam int  POOL_N     = 24;
    localparam logic [63:0] TAG_VLD  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TAG_2M   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TAG_KEY  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] ALL_ONES = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic              hit;
        logic [LEVEL_W-1:0] lvl;
        logic [ADDR_W-1:0] pa;
    } xlate_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [ADDR_W-1:0]  va;
        logic [ADDR_W-1:0]  pa;
        logic [LEVEL_W-1:0] lvl;
        logic               fixed;     // expected response typed in below
        xlate_t             want;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlbms_req_if req_ch ();
    tlbms_rsp_if rsp_ch ();

    two_level_multi_size_tlb u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the translation tables
    logic [63:0] g1_tag [L1_GIGA_ENTRIES];
    logic [47:0] g1_frm [L1_GIGA_ENTRIES];
    logic [63:0] h1_tag [L1_HUGE_ENTRIES];
    logic [47:0] h1_frm [L1_HUGE_ENTRIES];
    logic [63:0] b1_tag [L1_BASE_ENTRIES];
    logic [47:0] b1_frm [L1_BASE_ENTRIES];
    logic [63:0] g2_tag [L2_GIGA_ENTRIES];
    logic [47:0] g2_frm [L2_GIGA_ENTRIES];
    logic [63:0] m2_tag [L2_MIXED_ENTRIES];
    logic [47:0] m2_frm [L2_MIXED_ENTRIES];

    xlate_t pending_xlates [$];
    int     n_errors = 0;
    int     n_sent = 0;
    int     n_cycles = 0;
    bit     quiet = 1'b0;
    logic [47:0] va_pool [POOL_N];

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // one-at-a-time hash over the 8 bytes of the frame key, LSB first
    function automatic logic [31:0] oaat(input logic [63:0] key);
        logic [31:0] h;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            h += 32'(key[8*i +: 8]);
            h += h << 10;
            h ^= h >> 6;
        end
        h += h << 3;
        h ^= h >> 11;
        h += h << 15;
        return h;
    endfunction

    function automatic int slot(input logic [63:0] key, input int n);
        return int'(oaat(key) % 32'(n));
    endfunction

    function automatic int off_w(input logic [LEVEL_W-1:0] lvl);
        return (lvl == LVL_GIGA) ? OFF_GIGA : (lvl == LVL_HUGE) ? OFF_HUGE : OFF_BASE;
    endfunction

    function automatic logic [47:0] frame_of(input logic [47:0] a,
                                             input logic [LEVEL_W-1:0] lvl);
        return a & ~((48'd1 << off_w(lvl)) - 48'd1);
    endfunction

    task automatic clear_tables();
        foreach (g1_tag[i]) begin g1_tag[i] = '0; g1_frm[i] = '0; end
        foreach (h1_tag[i]) begin h1_tag[i] = '0; h1_frm[i] = '0; end
        foreach (b1_tag[i]) begin b1_tag[i] = '0; b1_frm[i] = '0; end
        foreach (g2_tag[i]) begin g2_tag[i] = '0; g2_frm[i] = '0; end
        foreach (m2_tag[i]) begin m2_tag[i] = '0; m2_frm[i] = '0; end
    endtask

    // 2: any entry, 1: must carry the 2 MB flag, 0: must not
    function automatic bit tag_match(input logic [63:0] t, input logic [47:0] key,
                                     input int want_2m);
        if (!(t & TAG_VLD) || (t & TAG_KEY) != 64'(key)) return 1'b0;
        if (want_2m == 1 && !(t & TAG_2M)) return 1'b0;
        if (want_2m == 0 && (t & TAG_2M)) return 1'b0;
        return 1'b1;
    endfunction

    function automatic xlate_t translate(input logic [47:0] va);
        xlate_t r;
        logic [47:0] kg, kh, kb, frm;
        int sg, sh, sb, tg, tm_h, tm_b;
        kg = frame_of(va, LVL_GIGA);
        kh = frame_of(va, LVL_HUGE);
        kb = frame_of(va, LVL_BASE);
        sg = slot(64'(kg), L1_GIGA_ENTRIES);
        sh = slot(64'(kh), L1_HUGE_ENTRIES);
        sb = slot(64'(kb), L1_BASE_ENTRIES);
        tg = slot(64'(kg), L2_GIGA_ENTRIES);
        tm_h = slot(64'(kh), L2_MIXED_ENTRIES);
        tm_b = slot(64'(kb), L2_MIXED_ENTRIES);
        r = '0;
        frm = '0;
        // probe order is fixed: first match wins
        if (tag_match(g1_tag[sg], kg, 2)) begin r.lvl = LVL_GIGA; frm = g1_frm[sg]; end
        else if (tag_match(h1_tag[sh], kh, 2)) begin r.lvl = LVL_HUGE; frm = h1_frm[sh]; end
        else if (tag_match(b1_tag[sb], kb, 2)) begin r.lvl = LVL_BASE; frm = b1_frm[sb]; end
        else if (tag_match(g2_tag[tg], kg, 2)) begin r.lvl = LVL_GIGA; frm = g2_frm[tg]; end
        else if (tag_match(m2_tag[tm_h], kh, 1)) begin
            r.lvl = LVL_HUGE; frm = m2_frm[tm_h];
        end else if (tag_match(m2_tag[tm_b], kb, 0)) begin
            r.lvl = LVL_BASE; frm = m2_frm[tm_b];
        end
        if (r.lvl != LVL_NONE) begin
            r.hit = 1'b1;
            r.pa  = frm + (va & ((48'd1 << off_w(r.lvl)) - 48'd1));
        end
        return r;
    endfunction

    task automatic map_page(input logic [47:0] va, input logic [47:0] pa,
                            input logic [LEVEL_W-1:0] lvl);
        logic [47:0] key, pf;
        logic [63:0] old, ntag;
        int s, d;
        key = frame_of(va, lvl);
        pf  = frame_of(pa, lvl);
        if (lvl == LVL_GIGA) begin
            s = slot(64'(key), L1_GIGA_ENTRIES);
            old = g1_tag[s];
            if ((old & TAG_VLD) && (old & TAG_KEY) != 64'(key)) begin
                d = slot(old & TAG_KEY, L2_GIGA_ENTRIES);
                g2_tag[d] = old;
                g2_frm[d] = g1_frm[s];
            end
            g1_tag[s] = TAG_VLD | 64'(key);
            g1_frm[s] = pf;
        end else if (lvl == LVL_HUGE) begin
            s = slot(64'(key), L1_HUGE_ENTRIES);
            old = h1_tag[s];
            if ((old & TAG_VLD) && (old & TAG_KEY) != 64'(key)) begin
                d = slot(old & TAG_KEY, L2_MIXED_ENTRIES);
                m2_tag[d] = old;
                m2_frm[d] = h1_frm[s];
            end
            h1_tag[s] = TAG_VLD | TAG_2M | 64'(key);
            h1_frm[s] = pf;
        end else begin
            s = slot(64'(key), L1_BASE_ENTRIES);
            old = b1_tag[s];
            ntag = TAG_VLD | 64'(key);
            if ((old & TAG_VLD) && (old & TAG_KEY) != 64'(key)) begin
                d = slot(old & TAG_KEY, L2_MIXED_ENTRIES);
                m2_tag[d] = old;
                m2_frm[d] = b1_frm[s];
            end
            b1_tag[s] = ntag;
            b1_frm[s] = pf;
        end
    endtask

    // Advance the shadow tables by one accepted request; queue a lookup answer
    task automatic apply_request(input stim_row_t r);
        xlate_t x;
        case (r.req)
            REQ_LOOKUP: begin
                x = translate(r.va);
                pending_xlates.push_back(r.fixed ? r.want : x);
            end
            REQ_INSERT: begin
                if (r.lvl == LVL_GIGA || r.lvl == LVL_HUGE || r.lvl == LVL_BASE)
                    map_page(r.va, r.pa, r.lvl);
            end
            REQ_FLUSH: clear_tables();
            default: ;
        endcase
    endtask

    // Offer one beat, hold it until taken, then sometimes drop valid for a random gap
    task automatic send(input stim_row_t r);
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.req;
        req_ch.vaddr      <= r.va;
        req_ch.paddr      <= r.pa;
        req_ch.page_level <= r.lvl;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        apply_request(r);
        n_sent++;
        quiet = (n_sent >= NUM_ITEMS - QUIET_TAIL);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    function automatic stim_row_t row(input logic [REQ_W-1:0] req, input logic [47:0] va,
                                      input logic [47:0] pa, input logic [LEVEL_W-1:0] lvl);
        stim_row_t r;
        r = '0;
        r.req = req; r.va = va; r.pa = pa; r.lvl = lvl;
        return r;
    endfunction

    function automatic stim_row_t row_chk(input logic [47:0] va, input logic h,
                                          input logic [LEVEL_W-1:0] lvl, input logic [47:0] pa);
        stim_row_t r;
        r = row(REQ_LOOKUP, va, '0, LVL_NONE);
        r.fixed = 1'b1;
        r.want  = '{hit: h, lvl: lvl, pa: pa};
        return r;
    endfunction

    // Pick an address that is likely to collide with recent mappings
    function automatic logic [47:0] fresh_va();
        logic [47:0] a;
        a = {$urandom, $urandom} & ALL_ONES;
        case ($urandom_range(0, 3))
            0: a[20:12] = '0;                 // 4 KB frame equal to its 2 MB frame
            1: a[47:32] = 16'($urandom_range(0, 3));
            default: ;
        endcase
        return a;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        logic [47:0] va, pa;
        int pick;
        pick = $urandom_range(0, 999);
        va = va_pool[$urandom_range(0, POOL_N - 1)];
        pa = {$urandom, $urandom} & ALL_ONES;
        if (pick < 600) begin
            // lookup: mostly a mapped page with a random offset
            if ($urandom_range(0, 4) != 0)
                va = (va & ~48'h3FFF_FFFF) | 48'($urandom_range(0, 32'h3FFF_FFFF)
                     & (($urandom_range(0, 1) != 0) ? 32'h3FFF_FFFF : 32'h001F_FFFF));
            else
                va = {$urandom, $urandom} & ALL_ONES;
            r = row(REQ_LOOKUP, va, pa, 3'($urandom_range(0, 7)));
        end else if (pick < 970) begin
            if ($urandom_range(0, 2) != 0) va = fresh_va();
            va_pool[$urandom_range(0, POOL_N - 1)] = va;
            r = row(REQ_INSERT, va, pa, ($urandom_range(0, 19) == 0)
                    ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 4)));
        end else if (pick < 985) begin
            r = row(REQ_FLUSH, va, pa, 3'($urandom_range(0, 7)));
        end else begin
            r = row(REQ_UNUSED, va, pa, 3'($urandom_range(0, 7)));
        end
        return r;
    endfunction

    // Receiver: random stall bursts plus one long hold-off so requests back up
    initial begin
        bit held;
        held = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held && n_sent >= HOLD_AT) begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Compare each response beat with the oldest outstanding lookup
    always @(posedge i_clk) begin
        xlate_t w;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_xlates.size() == 0) begin
                report("response beat with no lookup outstanding");
            end else begin
                w = pending_xlates.pop_front();
                if (rsp_ch.hit !== w.hit)
                    report($sformatf("hit %b, want %b", rsp_ch.hit, w.hit));
                if (rsp_ch.hit_level !== w.lvl)
                    report($sformatf("hit_level %0d, want %0d", rsp_ch.hit_level, w.lvl));
                if (rsp_ch.phys_addr !== w.pa)
                    report($sformatf("phys_addr %h, want %h", rsp_ch.phys_addr, w.pa));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_MAX) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        stim_row_t dir_rows [$];
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_LOOKUP;
        req_ch.vaddr      <= '0;
        req_ch.paddr      <= '0;
        req_ch.page_level <= LVL_NONE;
        clear_tables();
        foreach (va_pool[i]) va_pool[i] = fresh_va();

        // Directed rows: empty tables, address extremes, every request and
        // page level, ignored requests, in-place reinsert, flush
        dir_rows.push_back(row_chk(48'h0, 1'b0, LVL_NONE, 48'h0));
        dir_rows.push_back(row_chk(ALL_ONES, 1'b0, LVL_NONE, 48'h0));
        dir_rows.push_back(row(REQ_INSERT, ALL_ONES, ALL_ONES, LVL_GIGA));
        dir_rows.push_back(row_chk(ALL_ONES, 1'b1, LVL_GIGA, ALL_ONES));
        dir_rows.push_back(row(REQ_INSERT, 48'h0, 48'h0, LVL_BASE));
        dir_rows.push_back(row_chk(48'h0, 1'b1, LVL_BASE, 48'h0));
        dir_rows.push_back(row(REQ_INSERT, 48'h0000_0020_0000, 48'h5555_5555_5555, LVL_HUGE));
        dir_rows.push_back(row_chk(48'h0000_002A_BCDE, 1'b1, LVL_HUGE, 48'h5555_554A_BCDE));
        dir_rows.push_back(row(REQ_INSERT, 48'h0000_0040_0000, ALL_ONES, 3'd0));
        dir_rows.push_back(row(REQ_INSERT, 48'h0000_0040_0000, ALL_ONES, 3'd1));
        dir_rows.push_back(row(REQ_INSERT, 48'h0000_0040_0000, ALL_ONES, 3'd5));
        dir_rows.push_back(row(REQ_INSERT, 48'h0000_0040_0000, ALL_ONES, 3'd7));
        dir_rows.push_back(row(REQ_UNUSED, ALL_ONES, ALL_ONES, 3'd7));
        dir_rows.push_back(row_chk(48'h0000_0040_0000, 1'b0, LVL_NONE, 48'h0));
        dir_rows.push_back(row(REQ_INSERT, 48'h0000_0000_0456, 48'h0000_00AB_C000, LVL_BASE));
        dir_rows.push_back(row_chk(48'h0000_0000_0123, 1'b1, LVL_BASE, 48'h0000_00AB_C123));
        // 2 MB and 4 KB pages sharing one frame key, then churn to push them to L2
        dir_rows.push_back(row(REQ_INSERT, 48'h1230_0060_0000, 48'h2AAA_AAAA_AAAA, LVL_HUGE));
        dir_rows.push_back(row(REQ_INSERT, 48'h1230_0060_0000, 48'h1555_5555_5555, LVL_BASE));
        for (int i = 0; i < 4; i++)
            dir_rows.push_back(row(REQ_INSERT, 48'h1230_0060_0000 + 48'(i + 1) * 48'h20_0000,
                                   48'h0, (i % 2 == 0) ? LVL_HUGE : LVL_BASE));
        dir_rows.push_back(row(REQ_LOOKUP, 48'h1230_0060_0FFF, '0, LVL_NONE));
        dir_rows.push_back(row(REQ_FLUSH, ALL_ONES, ALL_ONES, LVL_BASE));
        dir_rows.push_back(row_chk(ALL_ONES, 1'b0, LVL_NONE, 48'h0));
        dir_rows.push_back(row_chk(48'h0, 1'b0, LVL_NONE, 48'h0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send(dir_rows[i]);
        while (n_sent < NUM_ITEMS) send(random_row());
        req_ch.valid <= 1'b0;

        // Drain: wait for the last lookup answer before the final report
        while (pending_xlates.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
